// File: design/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants of the sliding window receiver: word formats of
// both channels, result kinds and the control bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swr_pkg;

    // default configuration
    localparam int WINDOW_SIZE_DEF   = 8;
    localparam int SEQ_SPACE_DEF     = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    // fixed field widths of the channel words
    localparam int SEQ_W  = 4;
    localparam int DATA_W = 32;
    localparam int SLOT_W = 3;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ACK   = 1'b1;

    // arriving frame
    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic [DATA_W-1:0] payload;
    } t_in_word;

    // delivered frame or acknowledgement
    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  number;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] data_out;
        logic              last;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the arriving frame
        logic store;      // write frame into its slot, start the release scan
        logic issue;      // release the slot under the scan pointer
        logic load_frame; // put the released frame into the output register
        logic load_ack;   // put the acknowledgement into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic store_ok;   // frame is inside the window and its slot is free
        logic cur_full;   // slot under the scan pointer holds a frame
    } t_dp_status;

endpackage

// File: design/swr_ctrl.sv
// ----------------------------------------------------------------------------
// swr_ctrl
// Controller of the sliding window receiver: sequences capture, window check,
// in-order release scan and acknowledgement, and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  swr_pkg::t_dp_status   i_status,
    output swr_pkg::t_dp_cmd      o_cmd
);
    import swr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_ACK  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_pend;
    logic       n_pend;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_can_issue;

    // output register can take a word this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // a new release waits until the pending released frame can move to the output
    assign w_can_issue = !r_pend || (r_pend && w_out_free);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.store_ok) begin
                    o_cmd.store = 1'b1;
                    n_state     = ST_SCAN;
                end else begin
                    n_state = ST_ACK;
                end
            end
            ST_SCAN: begin
                o_cmd.load_frame = r_pend && w_out_free;
                if (w_can_issue) begin
                    if (i_status.cur_full) begin
                        o_cmd.issue = 1'b1;
                    end else begin
                        n_state = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                if (w_out_free) begin
                    o_cmd.load_ack = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // pending release and output valid
    always_comb begin
        if (o_cmd.issue) begin
            n_pend = 1'b1;
        end else if (o_cmd.load_frame) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end

        if (o_cmd.load_frame || o_cmd.load_ack) begin
            n_out_valid = 1'b1;
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // input side busy while a word is in flight or reset is held
    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

// File: design/swr_datapath.sv
// ----------------------------------------------------------------------------
// swr_datapath
// Datapath of the sliding window receiver: frame latch, window arithmetic,
// slot flags, frame store, release pointers and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swr_datapath #(
    parameter int WINDOW_SIZE   = swr_pkg::WINDOW_SIZE_DEF,
    parameter int SEQ_SPACE     = swr_pkg::SEQ_SPACE_DEF,
    parameter int PAYLOAD_WIDTH = swr_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swr_pkg::t_in_word     i_in_word,
    input  swr_pkg::t_dp_cmd      i_cmd,
    output swr_pkg::t_dp_status   o_status,
    output swr_pkg::t_out_word    o_out_word
);
    import swr_pkg::*;

    localparam int SW = $clog2(SEQ_SPACE);
    localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = ((SW > IW) ? SW : IW) + 1;
    localparam int RW = ((SW > SEQ_W) ? SW : SEQ_W) + 1;
    localparam int RED_STEPS = (1 << SEQ_W) / 2;

    // frame latch
    logic [SW-1:0]            r_seq;
    logic [PAYLOAD_WIDTH-1:0] r_data;

    // window state
    logic [WINDOW_SIZE-1:0]   r_full;
    logic [SW-1:0]            r_ne;
    logic [IW-1:0]            r_ne_mod;
    logic [IW-1:0]            r_cur;

    // frame store and released frame
    logic [PAYLOAD_WIDTH-1:0] r_mem [WINDOW_SIZE];
    logic [PAYLOAD_WIDTH-1:0] r_rdata;
    logic [SW-1:0]            r_pnum;
    logic [IW-1:0]            r_pslot;
    t_out_word                r_out;

    logic [RW-1:0]            w_seq_v;
    logic [CW-1:0]            w_seq_c;
    logic [CW-1:0]            w_ne_c;
    logic                     w_ge;
    logic [CW-1:0]            w_off;
    logic [CW-1:0]            w_sum;
    logic [CW-1:0]            w_wrap;
    logic [IW-1:0]            w_idx;
    logic                     w_in_win;
    logic                     w_ne_last;
    logic                     w_mod_last;
    logic                     w_cur_last;
    logic [SW-1:0]            w_ack_num;

    // arriving sequence number folded into the sequence space
    always_comb begin
        w_seq_v = RW'(i_in_word.seq_num);
        for (int k = 0; k < RED_STEPS; k++) begin
            if (w_seq_v >= RW'(SEQ_SPACE)) begin
                w_seq_v = w_seq_v - RW'(SEQ_SPACE);
            end
        end
    end

    // distance ahead of next expected, and the target slot
    assign w_seq_c  = CW'(r_seq);
    assign w_ne_c   = CW'(r_ne);
    assign w_ge     = (r_seq >= r_ne);
    assign w_off    = w_ge ? (w_seq_c - w_ne_c) : (w_seq_c + CW'(SEQ_SPACE) - w_ne_c);
    assign w_in_win = (w_off < CW'(WINDOW_SIZE));
    assign w_sum    = CW'(r_ne_mod) + w_off;
    assign w_wrap   = (w_sum >= CW'(WINDOW_SIZE)) ? (w_sum - CW'(WINDOW_SIZE)) : w_sum;
    // past the wrap of the sequence space the number itself is below the window size
    assign w_idx    = w_ge ? w_wrap[IW-1:0] : w_seq_c[IW-1:0];

    assign o_status.store_ok = w_in_win && !r_full[w_idx];
    assign o_status.cur_full = r_full[r_cur];

    // wrap points of the counters
    assign w_ne_last  = (r_ne == SW'(SEQ_SPACE - 1));
    assign w_mod_last = (r_ne_mod == IW'(WINDOW_SIZE - 1));
    assign w_cur_last = (r_cur == IW'(WINDOW_SIZE - 1));

    // acknowledged number is next expected minus one
    assign w_ack_num = (r_ne == '0) ? SW'(SEQ_SPACE - 1) : (r_ne - SW'(1));

    // slot flags and next expected
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= '0;
            r_ne     <= '0;
            r_ne_mod <= '0;
        end else begin
            if (i_cmd.store) begin
                r_full[w_idx] <= 1'b1;
            end
            if (i_cmd.issue) begin
                r_full[r_cur] <= 1'b0;
                if (w_ne_last) begin
                    r_ne     <= '0;
                    r_ne_mod <= '0;
                end else begin
                    r_ne     <= r_ne + SW'(1);
                    r_ne_mod <= w_mod_last ? '0 : (r_ne_mod + IW'(1));
                end
            end
        end
    end

    // frame latch and release pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_seq  <= w_seq_v[SW-1:0];
            r_data <= PAYLOAD_WIDTH'(i_in_word.payload);
        end
        if (i_cmd.store) begin
            r_cur <= r_ne_mod;
        end else if (i_cmd.issue) begin
            r_cur <= w_cur_last ? '0 : (r_cur + IW'(1));
        end
        if (i_cmd.issue) begin
            r_pnum  <= r_ne;
            r_pslot <= r_cur;
        end
    end

    // frame store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[w_idx] <= r_data;
        end
        if (i_cmd.issue) begin
            r_rdata <= r_mem[r_cur];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_frame) begin
            r_out.kind     <= KIND_FRAME;
            r_out.number   <= SEQ_W'(r_pnum);
            r_out.slot     <= SLOT_W'(r_pslot);
            r_out.data_out <= DATA_W'(r_rdata);
            r_out.last     <= 1'b0;
        end else if (i_cmd.load_ack) begin
            r_out.kind     <= KIND_ACK;
            r_out.number   <= SEQ_W'(w_ack_num);
            r_out.slot     <= '0;
            r_out.data_out <= '0;
            r_out.last     <= 1'b1;
        end
    end

    assign o_out_word = r_out;

endmodule

// File: design/sliding_window_receiver.sv
// ----------------------------------------------------------------------------
// sliding_window_receiver
// Selective repeat receiver. Each input word is one arriving frame; a frame
// within the window ahead of the next expected number is buffered in its
// slot (duplicates and out-of-window frames are dropped), then all buffered
// frames in order from the next expected number are delivered, one output
// word each, followed by one acknowledgement word of the last in-order number
// with last set. An input word releases up to the window size frames. It is
// latched, then checked against the window and written to its slot, then the
// release scan walks the slot flags and reads the frame store one slot a cycle
// while the output is not stalled, until it finds the end of the run, and
// then the acknowledgement is loaded. A dropped frame goes straight to the
// acknowledgement. Output stalls hold the release scan and the acknowledgement.
// Input is stalled until the acknowledgement sits in the output register.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_receiver #(
    parameter int WINDOW_SIZE   = swr_pkg::WINDOW_SIZE_DEF,
    parameter int SEQ_SPACE     = swr_pkg::SEQ_SPACE_DEF,
    parameter int PAYLOAD_WIDTH = swr_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swr_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swr_pkg::t_out_word   o_out_word
);
    import swr_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing
    swr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // window storage and arithmetic
    swr_datapath #(
        .WINDOW_SIZE   (WINDOW_SIZE),
        .SEQ_SPACE     (SEQ_SPACE),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

`ifndef SYNTHESIS
    // an accepted word keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // releases only happen from an occupied slot
    a_issue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> w_status.cur_full)
        else $error("release of an empty slot");

    // the acknowledgement closes the word and frees the input side
    a_ack_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_ack |=> (!o_in_stall && o_out_valid && o_out_word.last))
        else $error("acknowledgement did not end the word");

    // a frame and an ack never compete for the output register
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_frame && w_cmd.load_ack))
        else $error("two loads of the output register");
`endif

endmodule
